// ===== rtl/fwti_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and rule tables for the fuzzy wash-time pipeline
// no dependencies; imported by fwti_grade and fuzzy_wash_time_inference
package fwti_pkg;

    localparam int FRAC_BITS = 8;
    localparam int IN_W      = FRAC_BITS + 7;
    localparam int OUT_W     = FRAC_BITS + 6;
    localparam int CNT_W     = 3;
    localparam int GRADE_W   = FRAC_BITS + 6;
    localparam int POINT_W   = FRAC_BITS + 11;
    localparam int SUM_W     = FRAC_BITS + 13;
    localparam int RECIP_K   = 28;
    localparam int RECIP_W   = 24;
    localparam int PROD_W    = SUM_W + RECIP_W;

    typedef logic [GRADE_W-1:0] grade_t;
    typedef logic [POINT_W-1:0] point_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [RECIP_W-1:0] recip_t;

    typedef struct packed {
        grade_t g_small;
        grade_t g_medium;
        grade_t g_large;
    } grade_set_t;

    // full scale of a membership degree, and twice that
    localparam logic [IN_W-1:0] FULL_S  = IN_W'(50 << FRAC_BITS);
    localparam logic [IN_W-1:0] FULL_2S = IN_W'(100 << FRAC_BITS);

    localparam logic [2:0] SET_VSHORT = 3'd0;
    localparam logic [2:0] SET_SHORT  = 3'd1;
    localparam logic [2:0] SET_MEDIUM = 3'd2;
    localparam logic [2:0] SET_LONG   = 3'd3;
    localparam logic [2:0] SET_VLONG  = 3'd4;

    // output set by [dirt class][stain class], classes small, medium, large
    localparam logic [2:0] RULE_SET [3][3] = '{
        '{SET_VSHORT, SET_MEDIUM, SET_LONG},
        '{SET_SHORT,  SET_MEDIUM, SET_LONG},
        '{SET_MEDIUM, SET_LONG,   SET_VLONG}
    };

    // rule points in units of one twentieth of an lsb
    localparam point_t PT_VSHORT = POINT_W'(100 << FRAC_BITS);
    localparam point_t PT_SHORT  = POINT_W'(250 << FRAC_BITS);
    localparam point_t PT_MEDIUM = POINT_W'(500 << FRAC_BITS);
    localparam point_t PT_LONG   = POINT_W'(850 << FRAC_BITS);
    localparam point_t PT_VLONG  = POINT_W'(1000 << FRAC_BITS);

    // reciprocals of 20 * count, rounded up, scaled by 2^RECIP_K
    localparam recip_t RECIP_1 = RECIP_W'(((64'd1 << RECIP_K) + 64'd19) / 64'd20);
    localparam recip_t RECIP_2 = RECIP_W'(((64'd1 << RECIP_K) + 64'd39) / 64'd40);
    localparam recip_t RECIP_3 = RECIP_W'(((64'd1 << RECIP_K) + 64'd59) / 64'd60);
    localparam recip_t RECIP_4 = RECIP_W'(((64'd1 << RECIP_K) + 64'd79) / 64'd80);

    function automatic point_t point20(input logic [2:0] set, input grade_t n);
        point_t ne;
        begin
            ne = POINT_W'(n);
            unique case (set)
                SET_VSHORT: point20 = PT_VSHORT - (ne << 1);
                SET_SHORT:  point20 = PT_SHORT - ne;
                SET_MEDIUM: point20 = PT_MEDIUM;
                SET_LONG:   point20 = PT_LONG - ne;
                default:    point20 = PT_VLONG + (ne << 2);
            endcase
        end
    endfunction

endpackage

// ===== rtl/fuzzy_wash_time_inference.sv =====
`timescale 1ns / 1ps
// fuzzy wash-time inference: four-stage pipeline from level pair to wash time
// m_tvalid rises once an accepted item has passed the stage 1 to 4 registers; one item per cycle while m_tready is high
// stages: memberships, rule points, sum and count, reciprocal multiply
// each stage has its own valid bit and ready, so bubbles close up under a stall
// aresetn (synchronous, active low) clears the valid bits only
// depends on fwti_pkg and fwti_grade
module fuzzy_wash_time_inference (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // dirt_level [14:0], stain_level [29:15], zeros above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // wash_minutes [13:0], rules_fired [16:14], zeros above
);
    import fwti_pkg::*;

    // stage 1: memberships
    grade_set_t dirt_grd;
    grade_set_t stain_grd;
    grade_t     d_grd_reg [3];
    grade_t     s_grd_reg [3];
    logic       v1_reg;

    // stage 2: masked rule points
    point_t     pt_next [9];
    logic [8:0] fire_next;
    point_t     pt_reg [9];
    logic [8:0] fire_reg;
    logic       v2_reg;

    // stage 3: rounded numerator and count
    sum_t             num_next;
    logic [CNT_W-1:0] cnt_next;
    sum_t             num_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             v3_reg;

    // stage 4: result
    recip_t             recip;
    logic [PROD_W-1:0]  prod;
    logic [OUT_W-1:0]   mins_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               v4_reg;

    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    fwti_grade u_dirt_grade (
        .level  (s_tdata[IN_W-1:0]),
        .grades (dirt_grd)
    );

    fwti_grade u_stain_grade (
        .level  (s_tdata[2*IN_W-1:IN_W]),
        .grades (stain_grd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
        if (rdy1 && s_tvalid) begin
            d_grd_reg[0] <= dirt_grd.g_small;
            d_grd_reg[1] <= dirt_grd.g_medium;
            d_grd_reg[2] <= dirt_grd.g_large;
            s_grd_reg[0] <= stain_grd.g_small;
            s_grd_reg[1] <= stain_grd.g_medium;
            s_grd_reg[2] <= stain_grd.g_large;
        end
    end

    // min strength per rule, then its point; a zero strength or zero point is dropped
    always_comb begin
        grade_t n;
        point_t p;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n = (d_grd_reg[i] < s_grd_reg[j]) ? d_grd_reg[i] : s_grd_reg[j];
                p = point20(RULE_SET[i][j], n);
                fire_next[i*3+j] = (n != '0) && (p != '0);
                pt_next[i*3+j]   = fire_next[i*3+j] ? p : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
        if (rdy2 && v1_reg) begin
            pt_reg   <= pt_next;
            fire_reg <= fire_next;
        end
    end

    // at most two classes of each input are nonzero, so at most four rules fire
    always_comb begin
        sum_t acc;
        acc = '0;
        for (int k = 0; k < 9; k++) begin
            acc = acc + SUM_W'(pt_reg[k]);
        end
        cnt_next = CNT_W'($countones(fire_reg));
        num_next = acc + SUM_W'(cnt_next) * SUM_W'(10);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
        if (rdy3 && v2_reg) begin
            num_reg <= num_next;
            cnt_reg <= cnt_next;
        end
    end

    // division by 20 * count as a multiply by a rounded-up reciprocal
    always_comb begin
        case (cnt_reg)
            3'd1:    recip = RECIP_1;
            3'd2:    recip = RECIP_2;
            3'd3:    recip = RECIP_3;
            3'd4:    recip = RECIP_4;
            default: recip = '0;
        endcase
        prod = PROD_W'(num_reg) * PROD_W'(recip);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
        if (rdy4 && v3_reg) begin
            mins_reg    <= prod[RECIP_K+OUT_W-1:RECIP_K];
            out_cnt_reg <= cnt_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(24 - OUT_W - CNT_W){1'b0}}, out_cnt_reg, mins_reg};

`ifndef SYNTH
    a_cnt_range : assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (out_cnt_reg <= 3'd4))
        else $error("rules_fired above four");

    a_zero_when_none : assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && out_cnt_reg == '0) |-> (mins_reg == '0))
        else $error("nonzero wash time with no rule fired");

    a_mins_range : assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (mins_reg <= OUT_W'(60 << FRAC_BITS)))
        else $error("wash time above sixty minutes");

    a_cnt_matches_mask : assert property (@(posedge aclk) disable iff (!aresetn)
        (rdy3 && v2_reg) |=> (cnt_reg == CNT_W'($countones($past(fire_reg)))))
        else $error("stage 3 count lost its fire mask");

    a_stage1_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !rdy2) |=> (v1_reg && $stable(d_grd_reg[0]) && $stable(s_grd_reg[2])))
        else $error("stage 1 changed while stalled");
`endif

endmodule

// ===== rtl/fwti_grade.sv =====
`timescale 1ns / 1ps
// triangular medium and ramp-shaped small and large memberships of one level reading
// depends on fwti_pkg
module fwti_grade (
    input  logic [fwti_pkg::IN_W-1:0] level,
    output fwti_pkg::grade_set_t      grades
);
    import fwti_pkg::*;

    logic below_s;
    logic at_most_s;
    logic below_2s;

    assign below_s   = level < FULL_S;
    assign at_most_s = level <= FULL_S;
    assign below_2s  = level < FULL_2S;

    always_comb begin
        grades.g_small = below_s ? GRADE_W'(FULL_S - level) : '0;

        if (at_most_s) begin
            grades.g_medium = GRADE_W'(level);
        end else if (below_2s) begin
            grades.g_medium = GRADE_W'(FULL_2S - level);
        end else begin
            grades.g_medium = '0;
        end

        // saturates to full scale above the top of the range
        if (at_most_s) begin
            grades.g_large = '0;
        end else if (below_2s) begin
            grades.g_large = GRADE_W'(level - FULL_S);
        end else begin
            grades.g_large = GRADE_W'(FULL_S);
        end
    end

endmodule

// ===== tb/wash_time_checker.sv =====
`timescale 1ns / 1ps
// scoreboard for the fuzzy wash-time pipeline: predicts each result from its level pair
// watches both stream channels of the block; uses fwti_pkg for widths and the rule table
module wash_time_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // dirt_level [14:0], stain_level [29:15], zeros above
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // wash_minutes [13:0], rules_fired [16:14], zeros above
    output int          fail_count,
    output int          pending,
    output int          checked,
    output int          none_fired
);
    import fwti_pkg::*;

    typedef longint unsigned u64_t;

    localparam u64_t SCALE = u64_t'(50) << FRAC_BITS;

    typedef struct packed {
        logic [IN_W-1:0]  dirt;
        logic [IN_W-1:0]  stain;
        logic [OUT_W-1:0] minutes;
        logic [CNT_W-1:0] fired;
    } wash_result_t;

    wash_result_t expected_times[$];

    // small, medium, large membership numerators, full scale is SCALE
    function automatic void degrees(input u64_t x, output u64_t g[3]);
        g[0] = (x < SCALE) ? SCALE - x : 0;
        if (x <= SCALE)
            g[1] = x;
        else if (x < 2 * SCALE)
            g[1] = 2 * SCALE - x;
        else
            g[1] = 0;
        if (x <= SCALE)
            g[2] = 0;
        else if (x < 2 * SCALE)
            g[2] = x - SCALE;
        else
            g[2] = SCALE;
    endfunction

    function automatic wash_result_t predict_wash(input logic [IN_W-1:0] dirt,
                                                  input logic [IN_W-1:0] stain);
        u64_t         dg[3];
        u64_t         sg[3];
        u64_t         n;
        u64_t         pt;
        u64_t         total;
        u64_t         cnt;
        u64_t         mean;
        wash_result_t r;
        degrees(u64_t'(dirt), dg);
        degrees(u64_t'(stain), sg);
        total = 0;
        cnt   = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n = (dg[i] < sg[j]) ? dg[i] : sg[j];
                if (n != 0) begin
                    // points held in twentieths of an lsb so every set stays exact
                    case (RULE_SET[i][j])
                        SET_VSHORT: pt = (u64_t'(100) << FRAC_BITS) - 2 * n;
                        SET_SHORT:  pt = (u64_t'(250) << FRAC_BITS) - n;
                        SET_MEDIUM: pt = u64_t'(500) << FRAC_BITS;
                        SET_LONG:   pt = (u64_t'(850) << FRAC_BITS) - n;
                        default:    pt = (u64_t'(1000) << FRAC_BITS) + 4 * n;
                    endcase
                    if (pt != 0) begin
                        total += pt;
                        cnt++;
                    end
                end
            end
        end
        mean = (cnt != 0) ? (total + 10 * cnt) / (20 * cnt) : 0;
        r.dirt    = dirt;
        r.stain   = stain;
        r.minutes = OUT_W'(mean);
        r.fired   = CNT_W'(cnt);
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        wash_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_times.push_back(predict_wash(s_tdata[IN_W-1:0],
                                                      s_tdata[2*IN_W-1:IN_W]));
            if (m_tvalid && m_tready) begin
                if (expected_times.size() == 0) begin
                    $error("result with no item outstanding: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_times.pop_front();
                    checked++;
                    if (m_tdata[OUT_W+CNT_W-1:OUT_W] == '0)
                        none_fired++;
                    if (m_tdata[OUT_W-1:0] != want.minutes) begin
                        $error("wash_minutes: expected %0d, actual %0d (dirt %0d, stain %0d)",
                               want.minutes, m_tdata[OUT_W-1:0], want.dirt, want.stain);
                        fail_count++;
                    end
                    if (m_tdata[OUT_W+CNT_W-1:OUT_W] != want.fired) begin
                        $error("rules_fired: expected %0d, actual %0d (dirt %0d, stain %0d)",
                               want.fired, m_tdata[OUT_W+CNT_W-1:OUT_W],
                               want.dirt, want.stain);
                        fail_count++;
                    end
                    if (m_tdata[23:OUT_W+CNT_W] != '0) begin
                        $error("tdata padding: expected 0, actual %0h",
                               m_tdata[23:OUT_W+CNT_W]);
                        fail_count++;
                    end
                end
            end
            pending = expected_times.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// top of the wash-time testbench: clock, reset, level-pair stimulus and verdict
// depends on fwti_pkg, fuzzy_wash_time_inference and wash_time_checker
module testbench;
    import fwti_pkg::*;

    localparam int HALF_PERIOD      = 4;
    localparam int RANDOM_PER_PHASE = 600;
    localparam int LONG_STALL       = 200;
    localparam int DRAIN_CYCLES     = 12;
    localparam logic [IN_W-1:0] LEVEL_MAX = '1;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;     // dirt_level [14:0], stain_level [29:15], zeros above
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;           // wash_minutes [13:0], rules_fired [16:14], zeros above

    int fail_count;
    int pending;
    int checked;
    int none_fired;
    int tx_idle_pct;
    int rx_idle_pct;
    int stall_reqs;
    int stalls_done;
    int stall_left;
    int items_sent;
    int saturated;

    fuzzy_wash_time_inference dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wash_time_checker scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .none_fired (none_fired)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // receiver: random back-pressure, plus a long hold-off on request
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stalls_done != stall_reqs) begin
            m_tready    <= 1'b0;
            stalls_done <= stalls_done + 1;
            stall_left  <= LONG_STALL - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_levels(input logic [IN_W-1:0] dirt, input logic [IN_W-1:0] stain);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;   // junk while idle must be ignored
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, stain, dirt};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
        if (dirt > FULL_2S || stain > FULL_2S)
            saturated++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        while (pending != 0) @(negedge aclk);
    endtask

    // mostly in range, with weight on the breakpoints and some saturation
    function automatic logic [IN_W-1:0] pick_level();
        int v;
        case ($urandom_range(0, 9))
            0, 1: begin
                v = int'($urandom_range(0, 2)) * int'(FULL_S) + int'($urandom_range(0, 16)) - 8;
                if (v < 0)
                    v = 0;
            end
            2:       v = int'($urandom_range(0, int'(LEVEL_MAX)));
            default: v = int'($urandom_range(0, int'(FULL_2S)));
        endcase
        return IN_W'(v);
    endfunction

    initial begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // corners: both clean, both full, saturation, breakpoints, each output set
        send_levels(0, 0);
        send_levels(FULL_2S, FULL_2S);
        send_levels(LEVEL_MAX, LEVEL_MAX);
        send_levels(FULL_S, FULL_S);
        send_levels(0, FULL_2S);
        send_levels(FULL_2S, 0);
        send_levels(FULL_S, 0);
        send_levels(0, FULL_S);
        send_levels(FULL_S - 1, FULL_S + 1);
        send_levels(FULL_S + 1, FULL_S - 1);
        send_levels(FULL_2S - 1, 1);
        send_levels(1, FULL_2S - 1);
        send_levels(FULL_2S + 1, 30000);
        send_levels(6400, 19200);
        send_levels(19200, 6400);
        send_levels(LEVEL_MAX, 0);
        send_levels(0, LEVEL_MAX);
        send_levels(16384, 8192);
        send_levels(1, 1);
        send_levels(FULL_S, FULL_2S);
        send_levels(FULL_2S, FULL_S);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 33;
                    rx_idle_pct = 63;
                end
                1: begin
                    tx_idle_pct = 63;
                    rx_idle_pct = 33;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                // hold the output off while items keep coming so the pipeline backs up
                if (phase == 2 && k == 100)
                    stall_reqs++;
                send_levels(pick_level(), pick_level());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("%0d level pairs sent (%0d with a level above 100)", items_sent, saturated);
        $display("%0d results checked, %0d with no rule firing", checked, none_fired);
        $display("back-pressure: idle 33/63, then 63/33, then none, with a %0d-cycle stall",
                 LONG_STALL);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
